### sv/acper_pkg.sv
// shared constants and types for the ac presence edge-rate filter
package acper_pkg;

    localparam int LEVEL_W    = 2;
    localparam int ELAPSED_W  = 16;
    localparam int PERIOD_W   = 16;
    localparam int NOMINAL_W  = 10;
    localparam int DURATION_W = 32;
    localparam int EDGE_W     = 16;
    localparam int WINDOW_W   = 17;
    localparam int LIMIT_W    = 11;
    localparam int PRODUCT_W  = WINDOW_W + LIMIT_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    // sampled and filtered level codes
    localparam logic [LEVEL_W-1:0] LVL_UNKNOWN = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_OFF     = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_ON      = 2'd2;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_PERIOD = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NOMINAL_FREQ  = 1'd1;

    localparam logic [PERIOD_W-1:0]  WINDOW_PERIOD_RST = 16'd75;
    localparam logic [NOMINAL_W-1:0] NOMINAL_FREQ_RST  = 10'd50;

    localparam logic [LIMIT_W-1:0]    MS_PER_SEC   = 11'd1000;
    localparam logic [EDGE_W-1:0]     EDGE_MAX     = {EDGE_W{1'b1}};
    localparam logic [DURATION_W-1:0] DURATION_MAX = {DURATION_W{1'b1}};

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_UPDATE   = 6'b000010,
        ST_MUL_EDGE = 6'b000100,
        ST_MUL_LIM  = 6'b001000,
        ST_JUDGE    = 6'b010000,
        ST_DONE     = 6'b100000
    } state_t;

endpackage

### sv/ac_presence_edge_rate_filter.sv
// ac presence filter: edge counting over a time window with one shared multiplier
// a sample that closes a window passes ST_UPDATE, ST_MUL_EDGE, ST_MUL_LIM, ST_JUDGE and
//   ST_DONE (two passes through the shared multiplier); any other passes ST_UPDATE, ST_DONE
// a new sample is taken only in ST_IDLE, once the previous result is in the output register;
//   a result blocked by a full output register stalls the sequencer until the register drains
// reset (aresetn, synchronous, active low): levels unknown, tallies zero, 75 ms, 50 Hz
module ac_presence_edge_rate_filter (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [acper_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [acper_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // sample input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [acper_pkg::LEVEL_W-1:0]          s_raw_level,
    input  logic [acper_pkg::ELAPSED_W-1:0]        s_elapsed_ms,
    // result output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [acper_pkg::LEVEL_W-1:0]          m_stable_state,
    output logic [acper_pkg::DURATION_W-1:0]       m_stable_duration_ms,
    output logic                                   m_window_closed
);

    import acper_pkg::*;

    // sequencer
    state_t state_reg, state_next;

    // configuration
    logic [PERIOD_W-1:0]  period_reg,  period_next;
    logic [NOMINAL_W-1:0] nominal_reg, nominal_next;

    // captured sample
    logic [LEVEL_W-1:0]   level_reg,   level_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    // filter state
    logic [LEVEL_W-1:0]    prev_raw_reg,  prev_raw_next;
    logic [EDGE_W-1:0]     edge_reg,      edge_next;
    logic [WINDOW_W-1:0]   window_reg,    window_next;
    logic [LEVEL_W-1:0]    prior_reg,     prior_next;
    logic [LEVEL_W-1:0]    present_reg,   present_next;
    logic [DURATION_W-1:0] stable_reg,    stable_next;
    logic                  closed_reg,    closed_next;

    // products from the shared multiplier
    logic [PRODUCT_W-1:0] edge_scaled_reg, edge_scaled_next;
    logic [PRODUCT_W-1:0] lim_scaled_reg,  lim_scaled_next;

    // output register
    logic                  m_valid_reg,    m_valid_next;
    logic [LEVEL_W-1:0]    out_state_reg,  out_state_next;
    logic [DURATION_W-1:0] out_dur_reg,    out_dur_next;
    logic                  out_closed_reg, out_closed_next;

    // shared multiplier operands and result
    logic [WINDOW_W-1:0]  mul_a;
    logic [LIMIT_W-1:0]   mul_b;
    logic [PRODUCT_W-1:0] mul_p;

    // helpers
    logic [WINDOW_W-1:0]     window_sum;
    logic [DURATION_W:0]     stable_sum;
    logic [NOMINAL_W+1:0]    nominal_x3;
    logic [LIMIT_W-1:0]      limit_plus1;
    logic                    edge_seen;
    logic [LEVEL_W-1:0]      estimate;
    logic                    s_accept;

    assign s_accept = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    assign m_valid              = m_valid_reg;
    assign m_stable_state       = out_state_reg;
    assign m_stable_duration_ms = out_dur_reg;
    assign m_window_closed      = out_closed_reg;

    // on threshold is floor(nominal*6/4); rate > limit  <=>  edges*1000 >= (limit+1)*window
    assign nominal_x3  = {2'b00, nominal_reg} + {1'b0, nominal_reg, 1'b0};
    assign limit_plus1 = nominal_x3[LIMIT_W:1] + LIMIT_W'(1);

    // shared multiplier: edges by 1000 first, then window by limit+1
    always_comb begin
        if (state_reg == ST_MUL_EDGE) begin
            mul_a = {{(WINDOW_W-EDGE_W){1'b0}}, edge_reg};
            mul_b = MS_PER_SEC;
        end else begin
            mul_a = window_reg;
            mul_b = limit_plus1;
        end
    end
    assign mul_p = PRODUCT_W'(mul_a) * PRODUCT_W'(mul_b);

    // window and duration accumulation
    assign window_sum = window_reg + {{(WINDOW_W-ELAPSED_W){1'b0}}, elapsed_reg};
    assign stable_sum = {1'b0, stable_reg} + {{(DURATION_W+1-ELAPSED_W){1'b0}}, elapsed_reg};
    assign edge_seen  = (level_reg != LVL_UNKNOWN) && (level_reg != prev_raw_reg)
                        && (edge_reg != EDGE_MAX);

    // level estimate from a closed window: no edges or a zero rate means off, above the limit on, else unknown
    always_comb begin
        if (edge_reg == '0) begin
            estimate = LVL_OFF;
        end else if (edge_scaled_reg < {{(PRODUCT_W-WINDOW_W){1'b0}}, window_reg}) begin
            estimate = LVL_OFF;
        end else if (edge_scaled_reg >= lim_scaled_reg) begin
            estimate = LVL_ON;
        end else begin
            estimate = LVL_UNKNOWN;
        end
    end

    always_comb begin
        state_next       = state_reg;
        period_next      = period_reg;
        nominal_next     = nominal_reg;
        level_next       = level_reg;
        elapsed_next     = elapsed_reg;
        prev_raw_next    = prev_raw_reg;
        edge_next        = edge_reg;
        window_next      = window_reg;
        prior_next       = prior_reg;
        present_next     = present_reg;
        stable_next      = stable_reg;
        closed_next      = closed_reg;
        edge_scaled_next = edge_scaled_reg;
        lim_scaled_next  = lim_scaled_reg;
        m_valid_next     = m_valid_reg;
        out_state_next   = out_state_reg;
        out_dur_next     = out_dur_reg;
        out_closed_next  = out_closed_reg;

        // configuration writes take effect at once; the user keeps them to idle periods, the block does not enforce it
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_WINDOW_PERIOD: period_next  = cfg_wdata[PERIOD_W-1:0];
                CFG_NOMINAL_FREQ:  nominal_next = cfg_wdata[NOMINAL_W-1:0];
                default: ;
            endcase
        end

        // result transaction drains the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    level_next   = s_raw_level;
                    elapsed_next = s_elapsed_ms;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                closed_next   = 1'b0;
                prev_raw_next = level_reg;
                if (prev_raw_reg == LVL_UNKNOWN) begin
                    // resync after an unknown level
                    stable_next  = '0;
                    present_next = LVL_UNKNOWN;
                    state_next   = ST_DONE;
                end else begin
                    if (edge_seen) begin
                        edge_next = edge_reg + EDGE_W'(1);
                    end
                    window_next = window_sum;
                    stable_next = stable_sum[DURATION_W] ? DURATION_MAX
                                                         : stable_sum[DURATION_W-1:0];
                    if (window_sum >= {{(WINDOW_W-PERIOD_W){1'b0}}, period_reg}) begin
                        state_next = ST_MUL_EDGE;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL_EDGE: begin
                edge_scaled_next = mul_p;
                state_next       = ST_MUL_LIM;
            end
            ST_MUL_LIM: begin
                lim_scaled_next = mul_p;
                state_next      = ST_JUDGE;
            end
            ST_JUDGE: begin
                if (estimate != LVL_UNKNOWN) begin
                    present_next = estimate;
                    if (prior_reg != estimate) begin
                        stable_next = '0;
                        prior_next  = estimate;
                    end
                end
                window_next = '0;
                edge_next   = '0;
                closed_next = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    out_state_next  = present_reg;
                    out_dur_next    = stable_reg;
                    out_closed_next = closed_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            period_reg   <= WINDOW_PERIOD_RST;
            nominal_reg  <= NOMINAL_FREQ_RST;
            prev_raw_reg <= LVL_UNKNOWN;
            edge_reg     <= '0;
            window_reg   <= '0;
            prior_reg    <= LVL_UNKNOWN;
            present_reg  <= LVL_UNKNOWN;
            stable_reg   <= '0;
            closed_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            period_reg   <= period_next;
            nominal_reg  <= nominal_next;
            prev_raw_reg <= prev_raw_next;
            edge_reg     <= edge_next;
            window_reg   <= window_next;
            prior_reg    <= prior_next;
            present_reg  <= present_next;
            stable_reg   <= stable_next;
            closed_reg   <= closed_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        level_reg       <= level_next;
        elapsed_reg     <= elapsed_next;
        edge_scaled_reg <= edge_scaled_next;
        lim_scaled_reg  <= lim_scaled_next;
        out_state_reg   <= out_state_next;
        out_dur_reg     <= out_dur_next;
        out_closed_reg  <= out_closed_next;
    end

endmodule

### dv/tb_top.sv
// self-checking testbench for the ac presence edge-rate filter: scoreboard class and stimulus tasks
module tb_top;
    import acper_pkg::*;

    // raw level code with no meaning of its own, still counted as a known level
    localparam logic [LEVEL_W-1:0] LVL_SPARE = 2'd3;

    localparam int unsigned GAP_MAX     = 11;
    localparam int unsigned SETTLE_CYC  = 8;
    localparam int unsigned PHASE_ITEMS = 235;
    localparam int unsigned SHOW_MAX    = 40;

    typedef struct packed {
        logic [LEVEL_W-1:0]    state;
        logic [DURATION_W-1:0] duration_ms;
        logic                  closed;
    } presence_status_t;

    // tracks the filter state and holds the status reports still owed by the block
    class presence_scoreboard;
        logic [PERIOD_W-1:0]   period_ms;
        logic [NOMINAL_W-1:0]  nominal_hz;
        logic [LEVEL_W-1:0]    last_level;
        logic [EDGE_W-1:0]     edges;
        logic [WINDOW_W-1:0]   win_ms;
        logic [LEVEL_W-1:0]    held_state;
        logic [LEVEL_W-1:0]    cur_state;
        logic [DURATION_W-1:0] hold_ms;
        presence_status_t      status_due_q[$];
        int unsigned n_samples, n_checked, n_closed, n_on, n_off, n_sat, n_cfg, n_errors;

        function new();
            period_ms  = WINDOW_PERIOD_RST;
            nominal_hz = NOMINAL_FREQ_RST;
            last_level = LVL_UNKNOWN;
            edges      = '0;
            win_ms     = '0;
            held_state = LVL_UNKNOWN;
            cur_state  = LVL_UNKNOWN;
            hold_ms    = '0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            n_cfg++;
            if (idx == CFG_WINDOW_PERIOD) begin
                period_ms = data[PERIOD_W-1:0];
            end else begin
                nominal_hz = data[NOMINAL_W-1:0];
            end
        endfunction

        function int unsigned pending();
            return status_due_q.size();
        endfunction

        // level estimate from one closed window: off, on or no decision
        function logic [LEVEL_W-1:0] window_verdict();
            longint unsigned rate;
            longint unsigned limit;
            limit = (longint'(nominal_hz) * 2 * 3) / 4;
            if (edges == 0) return LVL_OFF;
            if (win_ms == 0) return LVL_ON;
            rate = (longint'(edges) * 1000) / longint'(win_ms);
            if (rate == 0) return LVL_OFF;
            if (rate > limit) return LVL_ON;
            return LVL_UNKNOWN;
        endfunction

        function void note_sample(logic [LEVEL_W-1:0] level, logic [ELAPSED_W-1:0] elapsed);
            presence_status_t due;
            logic [LEVEL_W-1:0] verdict;
            n_samples++;
            due.closed = 1'b0;
            if (last_level == LVL_UNKNOWN) begin
                last_level = level;
                hold_ms    = '0;
                cur_state  = LVL_UNKNOWN;
            end else begin
                if (level != LVL_UNKNOWN && level != last_level && edges != EDGE_MAX)
                    edges++;
                win_ms = win_ms + elapsed;
                if (hold_ms > DURATION_MAX - elapsed) hold_ms = DURATION_MAX;
                else hold_ms = hold_ms + elapsed;
                if (win_ms >= period_ms) begin
                    verdict = window_verdict();
                    if (verdict != LVL_UNKNOWN) begin
                        cur_state = verdict;
                        if (held_state != cur_state) begin
                            hold_ms    = '0;
                            held_state = cur_state;
                        end
                    end
                    if (verdict == LVL_ON) n_on++;
                    if (verdict == LVL_OFF) n_off++;
                    win_ms     = '0;
                    edges      = '0;
                    due.closed = 1'b1;
                    n_closed++;
                end
                last_level = level;
            end
            if (hold_ms == DURATION_MAX) n_sat++;
            due.state       = cur_state;
            due.duration_ms = hold_ms;
            status_due_q.push_back(due);
        endfunction

        function void flag(string what, longint unsigned exp_v, longint unsigned got_v);
            n_errors++;
            if (n_errors <= SHOW_MAX)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, got_v);
            if (n_errors == SHOW_MAX)
                $display("%0t: further mismatches are counted but not shown", $time);
        endfunction

        function void check_result(logic [LEVEL_W-1:0] st, logic [DURATION_W-1:0] dur,
                                   logic cl);
            presence_status_t due;
            n_checked++;
            if (status_due_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result: expected none, actual state %0d dur %0d closed %0d",
                         $time, st, dur, cl);
                return;
            end
            due = status_due_q.pop_front();
            if (st !== due.state) flag("stable_state", due.state, st);
            if (dur !== due.duration_ms) flag("stable_duration_ms", due.duration_ms, dur);
            if (cl !== due.closed) flag("window_closed", due.closed, cl);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [LEVEL_W-1:0]    s_raw_level;
    logic [ELAPSED_W-1:0]  s_elapsed_ms;
    logic                  m_valid;
    logic                  m_ready;
    logic [LEVEL_W-1:0]    m_stable_state;
    logic [DURATION_W-1:0] m_stable_duration_ms;
    logic                  m_window_closed;

    // when low, both sides run without gaps or stalls
    bit pace_on;

    presence_scoreboard board;

    ac_presence_edge_rate_filter u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_addr             (cfg_addr),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_raw_level          (s_raw_level),
        .s_elapsed_ms         (s_elapsed_ms),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_stable_state       (m_stable_state),
        .m_stable_duration_ms (m_stable_duration_ms),
        .m_window_closed      (m_window_closed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ends a hung run
    initial begin
        #100_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // every task below is entered and left at a falling edge

    // one sample transaction: optional gap, then hold valid until the block takes it
    task automatic send_sample(input logic [LEVEL_W-1:0] level,
                               input logic [ELAPSED_W-1:0] elapsed);
        int unsigned gap;
        gap = pace_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_raw_level  <= level;
        s_elapsed_ms <= elapsed;
        // ready as seen at the rising edge decides acceptance
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_sample(level, elapsed);
        @(negedge aclk);
    endtask

    // sender holds off until every owed result is back, then lets the block settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(negedge aclk); while (board.pending() != 0);
        repeat (SETTLE_CYC) @(negedge aclk);
    endtask

    // both registers in back-to-back cycles, only while the block is idle
    task automatic write_config(input logic [CFG_DATA_W-1:0] period,
                                input logic [CFG_DATA_W-1:0] nominal);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_WINDOW_PERIOD;
        cfg_wdata <= period;
        @(negedge aclk);
        board.set_reg(CFG_WINDOW_PERIOD, period);
        cfg_addr  <= CFG_NOMINAL_FREQ;
        cfg_wdata <= nominal;
        @(negedge aclk);
        board.set_reg(CFG_NOMINAL_FREQ, nominal);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // mains-like traffic in segments: each segment picks a toggle likelihood, a step size
    // and whether the two sides idle; unknown and spare codes are sprinkled in as noise
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned toggle_pick[4] = '{0, 25, 60, 95};
        int unsigned step_pick[5]   = '{0, 2, 6, 20, 200};
        int unsigned seg_left, toggle_pct, step_max, r;
        logic [LEVEL_W-1:0]   level;
        logic [LEVEL_W-1:0]   held;
        logic [ELAPSED_W-1:0] elapsed;
        held     = LVL_OFF;
        seg_left = 0;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (seg_left == 0) begin
                seg_left   = $urandom_range(8, 60);
                toggle_pct = toggle_pick[$urandom_range(0, 3)];
                step_max   = step_pick[$urandom_range(0, 4)];
                pace_on    = ($urandom_range(0, 3) != 0);
            end
            seg_left--;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                level = LVL_UNKNOWN;
            end else if (r < 6) begin
                level = LVL_SPARE;
            end else begin
                if ($urandom_range(0, 99) < toggle_pct)
                    held = (held == LVL_ON) ? LVL_OFF : LVL_ON;
                level = held;
            end
            if ($urandom_range(0, 19) == 0) elapsed = ELAPSED_W'($urandom);
            else elapsed = ELAPSED_W'($urandom_range(0, step_max));
            // halfway through, let the pipeline run empty once
            if (i == n_items / 2) drain();
            send_sample(level, elapsed);
        end
    endtask

    // result side: random stall per transaction, check at the accepting edge
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = pace_on ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.check_result(m_stable_state, m_stable_duration_ms, m_window_closed);
            @(negedge aclk);
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] phase_period[8];
        logic [CFG_DATA_W-1:0] phase_nominal[8];

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = CFG_WINDOW_PERIOD;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_raw_level  = LVL_UNKNOWN;
        s_elapsed_ms = '0;
        pace_on      = 1'b1;
        board        = new();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset register values (75 ms window, 50 hz)
        // unknown first sample keeps the previous level unknown
        send_sample(LVL_UNKNOWN, 16'hFFFF);
        send_sample(LVL_OFF, 16'd10);
        // eight level changes over 80 ms close a window at a rate of 100 per second: on
        for (int k = 0; k < 8; k++)
            send_sample((k % 2 == 0) ? LVL_ON : LVL_OFF, 16'd10);
        // one edge over the longest step rounds to zero edges/s: off
        send_sample(LVL_ON, 16'hFFFF);
        // spare code counts as an edge, unknown after known counts none
        send_sample(LVL_SPARE, 16'd5);
        send_sample(LVL_UNKNOWN, 16'd5);
        send_sample(LVL_OFF, 16'd7);
        send_sample(LVL_OFF, 16'd0);
        send_sample(LVL_OFF, 16'hFFFF);

        // zero window period: every sample after a known level closes, zero window time skips the divide
        write_config(16'd0, 16'd1023);
        send_sample(LVL_ON, 16'd0);
        send_sample(LVL_OFF, 16'd0);
        send_sample(LVL_OFF, 16'd0);
        send_sample(LVL_SPARE, 16'd0);
        send_sample(LVL_ON, 16'd1);

        // shortest period, lowest nominal
        write_config(16'd1, 16'd1);
        send_sample(LVL_OFF, 16'd1);
        send_sample(LVL_ON, 16'd1);
        send_sample(LVL_ON, 16'd2);

        // random phases over a spread of settings, extremes included
        phase_period  = '{16'd75, 16'd20, 16'd0, 16'hFFFF, 16'd1, 16'd300, 16'd0, 16'd0};
        phase_nominal = '{16'd50, 16'd60, 16'd1023, 16'd1, 16'd1, 16'd400, 16'd0, 16'd0};
        for (int p = 0; p < 8; p++) begin
            if (p >= 6) begin
                // random period, nominal with junk above the register width
                phase_period[p]  = CFG_DATA_W'($urandom_range(1, 150));
                phase_nominal[p] = CFG_DATA_W'($urandom);
            end
            pace_on = 1'b1;
            write_config(phase_period[p], phase_nominal[p]);
            run_random_phase(PHASE_ITEMS);
        end

        drain();
        $display("%0d samples and %0d results checked over %0d register writes;",
                 board.n_samples, board.n_checked, board.n_cfg);
        $display("%0d windows closed (%0d on, %0d off), %0d results at duration saturation",
                 board.n_closed, board.n_on, board.n_off, board.n_sat);
        if (board.n_errors == 0 && board.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
